// ----- design/prnp_pkg.sv -----
// Package of shared types for the polygon ring normal and plane unit.
`timescale 1ns / 1ps
`default_nettype none
package prnp_pkg;

   typedef enum logic [4:0] {
      S_LOAD, S_BOX_RD, S_BOX_UP, S_HIT_RD, S_HIT_UP, S_NRM_RD, S_NRM_CHK,
      S_RD_M, S_RD_P, S_CAP_P, S_XMUL, S_XSUB, S_SQMUL, S_SQADD, S_SQRT,
      S_ROOT_CHK, S_DIV_INIT, S_DIV, S_NEXT, S_FIN, S_DMUL, S_DADD, S_OUT
   } state_type;

   typedef enum logic [4:0] {
      CMD_LOAD, CMD_BOX_RD, CMD_BOX_UP, CMD_HIT_RD, CMD_HIT_UP, CMD_NRM_RD,
      CMD_NRM_CHK, CMD_RD_M, CMD_RD_P, CMD_CAP_P, CMD_XMUL, CMD_XSUB,
      CMD_SQMUL, CMD_SQADD, CMD_SQRT, CMD_ROOT_CHK, CMD_DIV_INIT, CMD_DIV,
      CMD_NEXT, CMD_FIN, CMD_DMUL, CMD_DADD, CMD_OUT
   } cmd_type;

   typedef struct packed {
      logic end_fire;
      logic last;
      logic big_ring;
      logic hit_match;
      logic root_zero;
      logic sqrt_done;
      logic div_done;
      logic comp_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ----- design/prnp_if.sv -----
// Request and response channel interfaces of the polygon ring normal and plane unit.
`timescale 1ns / 1ps
`default_nettype none
interface prnp_req_if #(parameter int COORD_BITS = 12);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] coord_x;
   logic signed [COORD_BITS-1:0] coord_y;
   logic signed [COORD_BITS-1:0] coord_z;
   logic                         outer_ring;
   logic                         ring_end;
   modport source (output valid, coord_x, coord_y, coord_z, outer_ring, ring_end,
                   input ready);
   modport sink (input valid, coord_x, coord_y, coord_z, outer_ring, ring_end,
                 output ready);
endinterface

interface prnp_rsp_if #(parameter int COORD_BITS = 12, parameter int FRAC_BITS = 14);
   logic                                   valid;
   logic                                   ready;
   logic signed [COORD_BITS-1:0]           box_min_x;
   logic signed [COORD_BITS-1:0]           box_max_x;
   logic signed [COORD_BITS-1:0]           box_min_y;
   logic signed [COORD_BITS-1:0]           box_max_y;
   logic signed [COORD_BITS-1:0]           box_min_z;
   logic signed [COORD_BITS-1:0]           box_max_z;
   logic signed [FRAC_BITS+1:0]            normal_x;
   logic signed [FRAC_BITS+1:0]            normal_y;
   logic signed [FRAC_BITS+1:0]            normal_z;
   logic signed [COORD_BITS+FRAC_BITS+1:0] plane_offset;
   logic                                   ring_solid;
   logic                                   normal_found;
   modport source (output valid, box_min_x, box_max_x, box_min_y, box_max_y,
                   box_min_z, box_max_z, normal_x, normal_y, normal_z,
                   plane_offset, ring_solid, normal_found, input ready);
   modport sink (input valid, box_min_x, box_max_x, box_min_y, box_max_y,
                 box_min_z, box_max_z, normal_x, normal_y, normal_z,
                 plane_offset, ring_solid, normal_found, output ready);
endinterface
`default_nettype wire

// ----- design/prnp_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module prnp_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ----- design/prnp_ctrl.sv -----
// Sequencing state machine of the polygon ring normal and plane unit.
`timescale 1ns / 1ps
`default_nettype none
module prnp_ctrl
   import prnp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire status_type status,
   output      cmd_type    cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD:     if (status.end_fire) state_in = S_BOX_RD;
         S_BOX_RD:   state_in = S_BOX_UP;
         S_BOX_UP:   state_in = status.last ? S_HIT_RD : S_BOX_RD;
         S_HIT_RD:   state_in = S_HIT_UP;
         S_HIT_UP: begin
            if (!status.last) state_in = S_HIT_RD;
            else if (status.big_ring) state_in = S_NRM_RD;
            else state_in = S_FIN;
         end
         S_NRM_RD:   state_in = S_NRM_CHK;
         S_NRM_CHK:  state_in = status.hit_match ? S_RD_M : S_NEXT;
         S_RD_M:     state_in = S_RD_P;
         S_RD_P:     state_in = S_CAP_P;
         S_CAP_P:    state_in = S_XMUL;
         S_XMUL:     state_in = S_XSUB;
         S_XSUB:     state_in = S_SQMUL;
         S_SQMUL:    state_in = S_SQADD;
         S_SQADD:    state_in = S_SQRT;
         S_SQRT:     if (status.sqrt_done) state_in = S_ROOT_CHK;
         S_ROOT_CHK: state_in = status.root_zero ? S_NEXT : S_DIV_INIT;
         S_DIV_INIT: state_in = S_DIV;
         S_DIV: begin
            if (status.div_done) state_in = status.comp_last ? S_NEXT : S_DIV_INIT;
         end
         S_NEXT:     state_in = status.last ? S_FIN : S_NRM_RD;
         S_FIN:      state_in = S_DMUL;
         S_DMUL:     state_in = S_DADD;
         S_DADD:     state_in = S_OUT;
         S_OUT:      if (status.out_free) state_in = S_LOAD;
         default:    state_in = S_LOAD;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         S_LOAD:     cmd = CMD_LOAD;
         S_BOX_RD:   cmd = CMD_BOX_RD;
         S_BOX_UP:   cmd = CMD_BOX_UP;
         S_HIT_RD:   cmd = CMD_HIT_RD;
         S_HIT_UP:   cmd = CMD_HIT_UP;
         S_NRM_RD:   cmd = CMD_NRM_RD;
         S_NRM_CHK:  cmd = CMD_NRM_CHK;
         S_RD_M:     cmd = CMD_RD_M;
         S_RD_P:     cmd = CMD_RD_P;
         S_CAP_P:    cmd = CMD_CAP_P;
         S_XMUL:     cmd = CMD_XMUL;
         S_XSUB:     cmd = CMD_XSUB;
         S_SQMUL:    cmd = CMD_SQMUL;
         S_SQADD:    cmd = CMD_SQADD;
         S_SQRT:     cmd = CMD_SQRT;
         S_ROOT_CHK: cmd = CMD_ROOT_CHK;
         S_DIV_INIT: cmd = CMD_DIV_INIT;
         S_DIV:      cmd = CMD_DIV;
         S_NEXT:     cmd = CMD_NEXT;
         S_FIN:      cmd = CMD_FIN;
         S_DMUL:     cmd = CMD_DMUL;
         S_DADD:     cmd = CMD_DADD;
         S_OUT:      cmd = CMD_OUT;
         default:    cmd = CMD_LOAD;
      endcase
   end
endmodule
`default_nettype wire

// ----- design/prnp_dp.sv -----
// Datapath of the polygon ring normal and plane unit: vertex store, box, normal and offset.
`timescale 1ns / 1ps
`default_nettype none
module prnp_dp
   import prnp_pkg::*;
#(
   parameter int MAX_VERTICES = 256,
   parameter int COORD_BITS   = 12,
   parameter int FRAC_BITS    = 14
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   output status_type   status,
   prnp_req_if.sink     req_bus,
   prnp_rsp_if.source   rsp_bus
);
   localparam int CB   = COORD_BITS;
   localparam int FB   = FRAC_BITS;
   localparam int AW   = $clog2(MAX_VERTICES);
   localparam int CNTW = $clog2(MAX_VERTICES + 1);
   localparam int VW   = 3 * CB;
   localparam int DW   = CB + 1;
   localparam int PW   = 2 * DW;
   localparam int XW   = PW + 1;
   localparam int SQW  = 2 * XW;
   localparam int SW   = SQW + 2;
   localparam int RW   = SW / 2;
   localparam int NUMW = XW + FB;
   localparam int NW   = FB + 2;
   localparam int DBW  = CB + FB + 2;
   localparam int DFW  = CB + NW + 2;
   localparam int ITW  = $clog2(NUMW + 1);

   logic [CNTW-1:0] count_ff;
   logic [AW-1:0]   idx_ff;
   logic [AW-1:0]   rd_addr;
   logic [VW-1:0]   rd_data;
   logic            wr_en;
   logic            fire;
   logic            last;
   logic            wrap;

   logic signed [CB-1:0] box_min_ff [3];
   logic signed [CB-1:0] box_max_ff [3];
   logic signed [CB-1:0] rd_comp    [3];
   logic signed [CB-1:0] vc_ff      [3];
   logic signed [CB-1:0] vm_ff      [3];
   logic signed [CB-1:0] vp_ff      [3];
   logic signed [CB-1:0] first_ff   [3];
   logic signed [CB-1:0] ring_first_ff [3];
   logic signed [DW-1:0] u_vec      [3];
   logic signed [DW-1:0] v_vec      [3];
   logic signed [PW-1:0] prod_ff    [6];
   logic signed [XW-1:0] cross_ff   [3];
   logic signed [SQW-1:0] sq_ff     [3];
   logic signed [NW-1:0] cand_ff    [3];
   logic signed [NW-1:0] pn_ff      [3];
   logic signed [CB+NW-1:0] dprod_ff [3];
   logic signed [DFW-1:0] d_ff;
   logic [2:0]           hits_now;
   logic [2:0]           top_ff;
   logic                 found_ff;
   logic                 solid_ff;
   logic                 outer_ff;

   logic [SW-1:0]   sq_src_ff;
   logic [RW+1:0]   sq_rem_ff;
   logic [RW-1:0]   root_ff;
   logic [RW+1:0]   rem_sh;
   logic [RW+1:0]   trial;
   logic [ITW-1:0]  iter_ff;
   logic [1:0]      comp_ff;
   logic [NUMW-1:0] div_q_ff;
   logic [RW-1:0]   div_rem_ff;
   logic [RW:0]     div_sh;
   logic [RW:0]     div_diff;
   logic            div_ge;
   logic [NUMW-1:0] div_q_next;
   logic [NW-1:0]   q_low;
   logic            div_neg_ff;
   logic signed [XW-1:0] c_sel;
   logic [XW-1:0]   c_abs;

   logic            rsp_valid_ff;
   logic            out_load;

   assign fire  = req_bus.valid && req_bus.ready;
   assign wr_en = fire && (count_ff < CNTW'(MAX_VERTICES));
   assign last  = (CNTW'(idx_ff) == (count_ff - CNTW'(1)));
   assign wrap  = (idx_ff == '0) || last;
   assign req_bus.ready = (cmd == CMD_LOAD);

   always_comb begin
      unique case (cmd)
         CMD_LOAD: rd_addr = idx_ff;
         CMD_RD_M: rd_addr = wrap ? AW'(count_ff - CNTW'(2)) : (idx_ff - AW'(1));
         CMD_RD_P: rd_addr = wrap ? AW'(1) : (idx_ff + AW'(1));
         default:  rd_addr = idx_ff;
      endcase
   end

   prnp_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({req_bus.coord_z, req_bus.coord_y, req_bus.coord_x}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      hits_now = '0;
      for (int k = 0; k < 3; k++) begin
         rd_comp[k] = rd_data[k*CB +: CB];
         if (rd_comp[k] == box_min_ff[k]) hits_now = hits_now + 3'd1;
         if (rd_comp[k] == box_max_ff[k]) hits_now = hits_now + 3'd1;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         u_vec[k] = $signed({vm_ff[k][CB-1], vm_ff[k]}) - $signed({vc_ff[k][CB-1], vc_ff[k]});
         v_vec[k] = $signed({vp_ff[k][CB-1], vp_ff[k]}) - $signed({vc_ff[k][CB-1], vc_ff[k]});
      end
   end

   // One step of the bit-pair square root and of the restoring divider.
   always_comb begin
      rem_sh     = {sq_rem_ff[RW-1:0], sq_src_ff[SW-1 -: 2]};
      trial      = {root_ff, 2'b01};
      div_sh     = {div_rem_ff, div_q_ff[NUMW-1]};
      div_diff   = div_sh - {1'b0, root_ff};
      div_ge     = (div_sh >= {1'b0, root_ff});
      div_q_next = {div_q_ff[NUMW-2:0], div_ge};
      q_low      = div_q_next[NW-1:0];
      c_sel      = cross_ff[comp_ff];
      c_abs      = c_sel[XW-1] ? (~c_sel + XW'(1)) : c_sel;
   end

   assign out_load = (cmd == CMD_OUT) && (!rsp_valid_ff || rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         top_ff       <= '0;
         found_ff     <= 1'b0;
         solid_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            box_min_ff[k] <= '0;
            box_max_ff[k] <= '0;
            pn_ff[k]      <= '0;
            first_ff[k]   <= '0;
         end
      end else begin
         rsp_valid_ff <= (rsp_valid_ff && !rsp_bus.ready) || out_load;
         case (cmd)
            CMD_LOAD: begin
               if (wr_en) begin
                  count_ff <= count_ff + CNTW'(1);
               end
               if (fire && (count_ff == '0)) begin
                  ring_first_ff[0] <= req_bus.coord_x;
                  ring_first_ff[1] <= req_bus.coord_y;
                  ring_first_ff[2] <= req_bus.coord_z;
               end
               if (fire && req_bus.ring_end) begin
                  outer_ff <= req_bus.outer_ring;
                  idx_ff   <= '0;
                  top_ff   <= '0;
                  found_ff <= 1'b0;
               end
            end
            CMD_BOX_UP: begin
               for (int k = 0; k < 3; k++) begin
                  if (idx_ff == '0 || rd_comp[k] < box_min_ff[k]) box_min_ff[k] <= rd_comp[k];
                  if (idx_ff == '0 || rd_comp[k] > box_max_ff[k]) box_max_ff[k] <= rd_comp[k];
               end
               idx_ff <= last ? '0 : idx_ff + AW'(1);
            end
            CMD_HIT_UP: begin
               if (hits_now > top_ff) top_ff <= hits_now;
               idx_ff <= last ? '0 : idx_ff + AW'(1);
            end
            CMD_NRM_CHK: begin
               for (int k = 0; k < 3; k++) vc_ff[k] <= rd_comp[k];
            end
            CMD_RD_P: begin
               for (int k = 0; k < 3; k++) vm_ff[k] <= rd_comp[k];
            end
            CMD_CAP_P: begin
               for (int k = 0; k < 3; k++) vp_ff[k] <= rd_comp[k];
            end
            CMD_XMUL: begin
               prod_ff[0] <= u_vec[1] * v_vec[2];
               prod_ff[1] <= u_vec[2] * v_vec[1];
               prod_ff[2] <= u_vec[2] * v_vec[0];
               prod_ff[3] <= u_vec[0] * v_vec[2];
               prod_ff[4] <= u_vec[0] * v_vec[1];
               prod_ff[5] <= u_vec[1] * v_vec[0];
            end
            CMD_XSUB: begin
               for (int k = 0; k < 3; k++) begin
                  cross_ff[k] <= $signed({prod_ff[2*k][PW-1], prod_ff[2*k]})
                               - $signed({prod_ff[2*k+1][PW-1], prod_ff[2*k+1]});
               end
            end
            CMD_SQMUL: begin
               for (int k = 0; k < 3; k++) sq_ff[k] <= cross_ff[k] * cross_ff[k];
            end
            CMD_SQADD: begin
               sq_src_ff <= {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
               sq_rem_ff <= '0;
               root_ff   <= '0;
               iter_ff   <= '0;
            end
            CMD_SQRT: begin
               sq_src_ff <= {sq_src_ff[SW-3:0], 2'b00};
               iter_ff   <= iter_ff + ITW'(1);
               if (rem_sh >= trial) begin
                  sq_rem_ff <= rem_sh - trial;
                  root_ff   <= {root_ff[RW-2:0], 1'b1};
               end else begin
                  sq_rem_ff <= rem_sh;
                  root_ff   <= {root_ff[RW-2:0], 1'b0};
               end
            end
            CMD_ROOT_CHK: begin
               comp_ff <= '0;
               if (root_ff != '0) found_ff <= 1'b1;
            end
            CMD_DIV_INIT: begin
               div_q_ff   <= {c_abs, {FB{1'b0}}};
               div_rem_ff <= '0;
               div_neg_ff <= c_sel[XW-1];
               iter_ff    <= '0;
            end
            CMD_DIV: begin
               div_q_ff   <= div_q_next;
               div_rem_ff <= div_ge ? div_diff[RW-1:0] : div_sh[RW-1:0];
               iter_ff    <= iter_ff + ITW'(1);
               if (iter_ff == ITW'(NUMW - 1)) begin
                  cand_ff[comp_ff] <= div_neg_ff ? (~q_low + NW'(1)) : q_low;
                  comp_ff          <= comp_ff + 2'd1;
               end
            end
            CMD_NEXT: begin
               idx_ff <= idx_ff + AW'(1);
            end
            CMD_FIN: begin
               if (outer_ff) begin
                  for (int k = 0; k < 3; k++) begin
                     first_ff[k] <= ring_first_ff[k];
                     pn_ff[k]    <= found_ff ? cand_ff[k] : '0;
                  end
                  solid_ff <= 1'b1;
               end else if (found_ff) begin
                  solid_ff <= !((pn_ff[0] == -cand_ff[0]) || (pn_ff[1] == -cand_ff[1]) ||
                                (pn_ff[2] == -cand_ff[2]));
               end else begin
                  solid_ff <= 1'b1;
               end
            end
            CMD_DMUL: begin
               for (int k = 0; k < 3; k++) dprod_ff[k] <= first_ff[k] * pn_ff[k];
            end
            CMD_DADD: begin
               d_ff <= $signed({{2{dprod_ff[0][CB+NW-1]}}, dprod_ff[0]})
                     + $signed({{2{dprod_ff[1][CB+NW-1]}}, dprod_ff[1]})
                     + $signed({{2{dprod_ff[2][CB+NW-1]}}, dprod_ff[2]});
            end
            CMD_OUT: begin
               if (out_load) count_ff <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_bus.box_min_x    <= box_min_ff[0];
         rsp_bus.box_max_x    <= box_max_ff[0];
         rsp_bus.box_min_y    <= box_min_ff[1];
         rsp_bus.box_max_y    <= box_max_ff[1];
         rsp_bus.box_min_z    <= box_min_ff[2];
         rsp_bus.box_max_z    <= box_max_ff[2];
         rsp_bus.normal_x     <= pn_ff[0];
         rsp_bus.normal_y     <= pn_ff[1];
         rsp_bus.normal_z     <= pn_ff[2];
         rsp_bus.plane_offset <= d_ff[DBW-1:0];
         rsp_bus.ring_solid   <= solid_ff;
         rsp_bus.normal_found <= found_ff;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;

   always_comb begin
      status.end_fire  = fire && req_bus.ring_end;
      status.last      = last;
      status.big_ring  = (count_ff >= CNTW'(3));
      status.hit_match = (hits_now == top_ff);
      status.root_zero = (root_ff == '0);
      status.sqrt_done = (iter_ff == ITW'(RW - 1));
      status.div_done  = (iter_ff == ITW'(NUMW - 1));
      status.comp_last = (comp_ff == 2'd2);
      status.out_free  = out_load;
   end
endmodule
`default_nettype wire

// ----- design/polygon_ring_normal_plane_unit.sv -----
// Top level of the polygon ring normal and plane unit.
// Vertices are taken one word per cycle; a ring-end word starts processing of the ring.
// The ring is scanned once for its bounding box and once for its extreme vertices; with three or
// more vertices each extreme vertex gets a cross product and its square root, and a divide per
// component when its cross product is nonzero. No word is taken until the result is registered.
// Reset is synchronous and clears the vertex count, ring box, polygon normal and flags.
`timescale 1ns / 1ps
`default_nettype none
module polygon_ring_normal_plane_unit
   import prnp_pkg::*;
#(
   parameter int MAX_VERTICES = 256,
   parameter int COORD_BITS   = 12,
   parameter int FRAC_BITS    = 14
) (
   input wire logic   clock,
   input wire logic   reset,
   prnp_req_if.sink   req_bus,
   prnp_rsp_if.source rsp_bus
);
   cmd_type    cmd;
   status_type status;

   prnp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   prnp_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS),
      .FRAC_BITS    (FRAC_BITS)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .status  (status),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );
endmodule
`default_nettype wire
